>>> rtl/byte_alu_execute_with_flags_unit_macros.svh
// Assertion macros shared by the byte ALU execute unit.
`ifndef BYTE_ALU_EXECUTE_WITH_FLAGS_UNIT_MACROS_SVH
`define BYTE_ALU_EXECUTE_WITH_FLAGS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define BAFU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define BAFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define BAFU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BAFU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/bafu_pkg.sv
// Shared types, widths and constants of the byte ALU execute unit.
`default_nettype none

package bafu_pkg;

  // Field widths
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned REG_IDX_W = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PC_W      = 16;
  localparam int unsigned FLAGS_W   = 5;

  // Default sizes of the register file and data memory
  localparam int unsigned NUM_REGS_DEF   = 64;
  localparam int unsigned DATA_DEPTH_DEF = 256;

  // Status bit positions
  localparam int unsigned FLAG_C_BIT = 4;
  localparam int unsigned FLAG_V_BIT = 3;
  localparam int unsigned FLAG_N_BIT = 2;
  localparam int unsigned FLAG_S_BIT = 1;
  localparam int unsigned FLAG_Z_BIT = 0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_XOR  = 4'd3,
    CMD_BR   = 4'd4,
    CMD_MOVI = 4'd5,
    CMD_BEQZ = 4'd6,
    CMD_ANDI = 4'd7,
    CMD_SAL  = 4'd8,
    CMD_SAR  = 4'd9,
    CMD_LDR  = 4'd10,
    CMD_STR  = 4'd11
  } cmd_e;

  // Outcome of one instruction, from the ALU to the write-back logic
  typedef struct packed {
    logic [BYTE_W-1:0]  result;
    logic [FLAGS_W-1:0] flags;
    logic               taken;
    logic [PC_W-1:0]    target;
    logic               rf_we;
    logic               dm_we;
    logic               flags_we;
  } alu_res_t;

endpackage

`default_nettype wire

>>> rtl/bafu_if.sv
// Valid/ready channel interfaces for instruction items and result items.
`default_nettype none

interface bafu_in_if;
  import bafu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [REG_IDX_W-1:0] dest_reg;
  logic [REG_IDX_W-1:0] src_reg;
  logic [BYTE_W-1:0]    imm;
  logic [PC_W-1:0]      pc;

  modport source (output valid, command, dest_reg, src_reg, imm, pc, input ready);
  modport sink   (input valid, command, dest_reg, src_reg, imm, pc, output ready);
endinterface

interface bafu_out_if;
  import bafu_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  result_value;
  logic [FLAGS_W-1:0] flags;
  logic               branch_taken;
  logic [PC_W-1:0]    branch_target;

  modport source (output valid, result_value, flags, branch_taken, branch_target,
                  input ready);
  modport sink   (input valid, result_value, flags, branch_taken, branch_target,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/bafu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bafu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, returns the old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bafu_alu.sv
// Byte ALU: arithmetic, logic, shifts, branches and load/store selection.
`default_nettype none

module bafu_alu (
  input  logic [bafu_pkg::CMD_W-1:0]   cmd_i,
  input  logic [bafu_pkg::BYTE_W-1:0]  a_i,
  input  logic [bafu_pkg::BYTE_W-1:0]  b_i,
  input  logic [bafu_pkg::BYTE_W-1:0]  mem_i,
  input  logic                         mem_ok_i,
  input  logic [bafu_pkg::BYTE_W-1:0]  imm_i,
  input  logic [bafu_pkg::PC_W-1:0]    pc_i,
  input  logic [bafu_pkg::FLAGS_W-1:0] flags_i,
  output bafu_pkg::alu_res_t           res_o
);
  import bafu_pkg::*;

  cmd_e               cmd;
  logic [BYTE_W:0]    sum;
  logic [BYTE_W-1:0]  diff;
  logic signed [2*BYTE_W-1:0] prod;
  logic signed [BYTE_W-1:0]   sar_v;
  logic               shift_big;
  logic [PC_W-1:0]    beqz_tgt;
  logic [FLAGS_W-1:0] nf;
  logic [BYTE_W-1:0]  res;

  assign cmd       = cmd_e'(cmd_i);
  assign sum       = {1'b0, a_i} + {1'b0, b_i};
  assign diff      = a_i - b_i;
  assign prod      = $signed(a_i) * $signed(b_i);
  assign sar_v     = $signed(a_i) >>> imm_i[2:0];
  assign shift_big = |imm_i[BYTE_W-1:3];
  assign beqz_tgt  = pc_i + {{(PC_W-1){1'b0}}, 1'b1} + {{(PC_W-BYTE_W){imm_i[BYTE_W-1]}}, imm_i};

  // Decode the command into result, new flags and write enables
  always_comb begin
    res            = '0;
    nf             = '0;
    res_o.taken    = 1'b0;
    res_o.target   = '0;
    res_o.rf_we    = 1'b0;
    res_o.dm_we    = 1'b0;
    res_o.flags_we = 1'b0;
    case (cmd)
      CMD_ADD: begin
        res                = sum[BYTE_W-1:0];
        nf[FLAG_C_BIT]     = sum[BYTE_W];
        nf[FLAG_V_BIT]     = (a_i[7] == b_i[7]) && (a_i[7] != res[7]);
        nf[FLAG_N_BIT]     = res[7];
        nf[FLAG_Z_BIT]     = (res == '0);
        nf[FLAG_S_BIT]     = nf[FLAG_N_BIT] ^ nf[FLAG_V_BIT];
        res_o.rf_we        = 1'b1;
        res_o.flags_we     = 1'b1;
      end
      CMD_SUB: begin
        res                = diff;
        nf[FLAG_V_BIT]     = (a_i[7] != b_i[7]) && (a_i[7] != res[7]);
        nf[FLAG_N_BIT]     = res[7];
        nf[FLAG_Z_BIT]     = (res == '0);
        nf[FLAG_S_BIT]     = nf[FLAG_N_BIT] ^ nf[FLAG_V_BIT];
        res_o.rf_we        = 1'b1;
        res_o.flags_we     = 1'b1;
      end
      CMD_MUL: begin
        res                = prod[BYTE_W-1:0];
        nf[FLAG_N_BIT]     = prod[2*BYTE_W-1];
        nf[FLAG_Z_BIT]     = (prod == '0);
        res_o.rf_we        = 1'b1;
        res_o.flags_we     = 1'b1;
      end
      CMD_XOR, CMD_ANDI, CMD_SAL, CMD_SAR: begin
        case (cmd)
          CMD_XOR:  res = a_i ^ b_i;
          CMD_ANDI: res = a_i & imm_i;
          CMD_SAL:  res = shift_big ? '0 : (a_i << imm_i[2:0]);
          default:  res = shift_big ? {BYTE_W{a_i[7]}} : sar_v;
        endcase
        nf[FLAG_N_BIT]     = res[7];
        nf[FLAG_S_BIT]     = res[7];
        nf[FLAG_Z_BIT]     = (res == '0);
        res_o.rf_we        = 1'b1;
        res_o.flags_we     = 1'b1;
      end
      CMD_BR: begin
        res_o.taken  = 1'b1;
        res_o.target = {a_i, b_i};
      end
      CMD_MOVI: begin
        res         = imm_i;
        res_o.rf_we = 1'b1;
      end
      CMD_BEQZ: begin
        if (a_i == '0) begin
          res_o.taken  = 1'b1;
          res_o.target = beqz_tgt;
        end
      end
      CMD_LDR: begin
        res         = mem_ok_i ? mem_i : '0;
        res_o.rf_we = 1'b1;
      end
      CMD_STR: begin
        res         = mem_ok_i ? a_i : '0;
        res_o.dm_we = mem_ok_i;
      end
      default: begin
        res = '0;
      end
    endcase
    res_o.result = res;
    res_o.flags  = res_o.flags_we ? nf : flags_i;
  end

endmodule

`default_nettype wire

>>> rtl/byte_alu_execute_with_flags_unit.sv
// Top level of the byte ALU execute unit: RAM read, execute, write back, result register.
`default_nettype none
`include "byte_alu_execute_with_flags_unit_macros.svh"

// Byte ALU execute unit. Takes one instruction item per clock while the output
// is not stalled and returns one result item per instruction, in order. The
// edge that accepts an item starts the register-file and data-memory reads; the
// edge on which the execute stage then advances executes it, writes back and
// loads the result register, which offers the result item. Sustained rate is
// one item per cycle while the output is not stalled, with the read/modify/write
// through the register file and data memory RAMs and the previous instruction's
// write forwarded to the one behind it. After reset a clearing pass over
// max(NUM_REGS, DATA_DEPTH) addresses (256 with the default sizes) writes zero
// to every register and memory byte; the input is held off until it ends.
// Output stalls hold the execute stage; input is taken when it is empty or moves.
module byte_alu_execute_with_flags_unit #(
  parameter int unsigned NUM_REGS   = bafu_pkg::NUM_REGS_DEF,
  parameter int unsigned DATA_DEPTH = bafu_pkg::DATA_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  bafu_in_if.sink    in_i,
  bafu_out_if.source out_o
);
  import bafu_pkg::*;

  localparam int unsigned RF_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned DM_AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam logic [8:0]  RF_LIMIT = 9'(NUM_REGS);
  localparam logic [8:0]  DM_LIMIT = 9'(DATA_DEPTH);
  localparam int unsigned CLR_N    = (NUM_REGS > DATA_DEPTH) ? NUM_REGS : DATA_DEPTH;
  localparam logic [8:0]  CLR_LAST = 9'(CLR_N - 1);

  // Handshake
  logic in_acc;
  logic s1_adv;

  // Execute stage
  logic                 s1_valid_q;
  logic [CMD_W-1:0]     s1_cmd_q;
  logic [REG_IDX_W-1:0] s1_rd_q;
  logic [REG_IDX_W-1:0] s1_rs_q;
  logic [BYTE_W-1:0]    s1_imm_q;
  logic [PC_W-1:0]      s1_pc_q;

  // Status register
  logic [FLAGS_W-1:0] flags_q;

  // RAM read data
  logic [BYTE_W-1:0] rf_a_q;
  logic [BYTE_W-1:0] rf_b_q;
  logic [BYTE_W-1:0] dm_q;

  // Clearing pass after reset
  logic       clr_busy_q;
  logic [8:0] clr_cnt_q;

  // RAM write ports
  logic              rf_wen;
  logic [RF_AW-1:0]  rf_waddr;
  logic [BYTE_W-1:0] rf_wdata;
  logic              dm_wen;
  logic [DM_AW-1:0]  dm_waddr;
  logic [BYTE_W-1:0] dm_wdata;

  // Last-write forwarding
  logic                 fwd_rf_v_q;
  logic [REG_IDX_W-1:0] fwd_rf_addr_q;
  logic [BYTE_W-1:0]    fwd_rf_data_q;
  logic                 fwd_dm_v_q;
  logic [BYTE_W-1:0]    fwd_dm_addr_q;
  logic [BYTE_W-1:0]    fwd_dm_data_q;

  // Output register
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_result_q;
  logic [FLAGS_W-1:0] out_flags_q;
  logic               out_taken_q;
  logic [PC_W-1:0]    out_target_q;

  // Operand selection
  logic [7:0]        in_rd_ext;
  logic [7:0]        in_rs_ext;
  logic [7:0]        s1_rd_ext;
  logic [RF_AW-1:0]  s1_rd_idx;
  logic [DM_AW-1:0]  s1_dm_idx;
  logic              rd_ok;
  logic              rs_ok;
  logic              dm_ok;
  logic [BYTE_W-1:0] op_a;
  logic [BYTE_W-1:0] op_b;
  logic [BYTE_W-1:0] op_mem;
  alu_res_t          alu_res;
  logic              rf_we;
  logic              dm_we;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_i.valid && in_i.ready;

  assign in_rd_ext = {2'b00, in_i.dest_reg};
  assign in_rs_ext = {2'b00, in_i.src_reg};
  assign s1_rd_ext = {2'b00, s1_rd_q};
  assign s1_rd_idx = s1_rd_ext[RF_AW-1:0];
  assign s1_dm_idx = s1_imm_q[DM_AW-1:0];

  assign rd_ok = ({3'b000, s1_rd_q} < RF_LIMIT);
  assign rs_ok = ({3'b000, s1_rs_q} < RF_LIMIT);
  assign dm_ok = ({1'b0, s1_imm_q} < DM_LIMIT);

  // Pick forwarded, stored or out-of-range value for each operand
  always_comb begin
    op_a = '0;
    if (rd_ok) begin
      if (fwd_rf_v_q && (fwd_rf_addr_q == s1_rd_q)) begin
        op_a = fwd_rf_data_q;
      end else begin
        op_a = rf_a_q;
      end
    end
    op_b = '0;
    if (rs_ok) begin
      if (fwd_rf_v_q && (fwd_rf_addr_q == s1_rs_q)) begin
        op_b = fwd_rf_data_q;
      end else begin
        op_b = rf_b_q;
      end
    end
    op_mem = '0;
    if (dm_ok) begin
      if (fwd_dm_v_q && (fwd_dm_addr_q == s1_imm_q)) begin
        op_mem = fwd_dm_data_q;
      end else begin
        op_mem = dm_q;
      end
    end
  end

  bafu_alu u_alu (
    .cmd_i    (s1_cmd_q),
    .a_i      (op_a),
    .b_i      (op_b),
    .mem_i    (op_mem),
    .mem_ok_i (dm_ok),
    .imm_i    (s1_imm_q),
    .pc_i     (s1_pc_q),
    .flags_i  (flags_q),
    .res_o    (alu_res)
  );

  assign rf_we = s1_adv && alu_res.rf_we && rd_ok;
  assign dm_we = s1_adv && alu_res.dm_we;

  // Clear the register file and data memory after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 9'd1;
      if (clr_cnt_q == CLR_LAST) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Steer the write ports to the clearing pass or to write-back
  assign rf_wen   = clr_busy_q ? (clr_cnt_q < RF_LIMIT) : rf_we;
  assign rf_waddr = clr_busy_q ? clr_cnt_q[RF_AW-1:0] : s1_rd_idx;
  assign rf_wdata = clr_busy_q ? '0 : alu_res.result;
  assign dm_wen   = clr_busy_q ? (clr_cnt_q < DM_LIMIT) : dm_we;
  assign dm_waddr = clr_busy_q ? clr_cnt_q[DM_AW-1:0] : s1_dm_idx;
  assign dm_wdata = clr_busy_q ? '0 : op_a;

  // Register file, two copies for two read ports
  bafu_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_REGS), .AW(RF_AW)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_wen),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (in_acc),
    .raddr_i (in_rd_ext[RF_AW-1:0]),
    .rdata_o (rf_a_q)
  );

  bafu_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_REGS), .AW(RF_AW)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_wen),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (in_acc),
    .raddr_i (in_rs_ext[RF_AW-1:0]),
    .rdata_o (rf_b_q)
  );

  // Data memory
  bafu_ram #(.WIDTH(BYTE_W), .DEPTH(DATA_DEPTH), .AW(DM_AW)) u_dm (
    .clk_i   (clk_i),
    .we_i    (dm_wen),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (in_acc),
    .raddr_i (in_i.imm[DM_AW-1:0]),
    .rdata_o (dm_q)
  );

  // Advance the execute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q <= in_i.command;
      s1_rd_q  <= in_i.dest_reg;
      s1_rs_q  <= in_i.src_reg;
      s1_imm_q <= in_i.imm;
      s1_pc_q  <= in_i.pc;
    end
  end

  // Update status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (s1_adv && alu_res.flags_we) begin
      flags_q <= alu_res.flags;
    end
  end

  // Capture the write that coincides with the next item's read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_rf_v_q <= 1'b0;
      fwd_dm_v_q <= 1'b0;
    end else if (in_acc) begin
      fwd_rf_v_q <= rf_we;
      fwd_dm_v_q <= dm_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_rf_addr_q <= s1_rd_q;
      fwd_rf_data_q <= alu_res.result;
      fwd_dm_addr_q <= s1_imm_q;
      fwd_dm_data_q <= op_a;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_result_q <= alu_res.result;
      out_flags_q  <= alu_res.flags;
      out_taken_q  <= alu_res.taken;
      out_target_q <= alu_res.target;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_value  = out_result_q;
  assign out_o.flags         = out_flags_q;
  assign out_o.branch_taken  = out_taken_q;
  assign out_o.branch_target = out_target_q;

  // Checks
  `BAFU_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni,
                    s1_valid_q && out_valid_q && !out_o.ready,
                    s1_valid_q && $stable(s1_cmd_q) && $stable(s1_rd_q))
  `BAFU_ASSERT_NEXT(a_fwd_capture, clk_i, rst_ni,
                    in_acc && rf_we,
                    fwd_rf_v_q && (fwd_rf_addr_q == $past(s1_rd_q)))
  `BAFU_ASSERT_IMPL(a_flags_match, clk_i, rst_ni,
                    out_valid_q,
                    out_flags_q == flags_q)

endmodule

`default_nettype wire
